// ===== sv/ascii_pixel_row_column_picker_assert.svh =====
// Assertion macros for the row/column picker.
`ifndef ASCII_PIXEL_ROW_COLUMN_PICKER_ASSERT_SVH
`define ASCII_PIXEL_ROW_COLUMN_PICKER_ASSERT_SVH

// same-cycle implication
`define APPCP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define APPCP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/appcp_pkg.sv =====
// ----------------------------------------------------------------------------
// appcp_pkg
// Shared widths, codes and result type of the ASCII pixel row/column picker.
// ----------------------------------------------------------------------------
`default_nettype none

package appcp_pkg;

    localparam int MAX_LEDS_DEF = 128;
    localparam int CHANNELS_DEF = 3;
    localparam int POS_W_DEF    = 16;

    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int LED_W      = 7;
    localparam int CH_W       = 2;
    localparam int MAPPOS_W   = 16;
    localparam int VAL_W      = 8;
    localparam int HDR_W      = 4;
    localparam int LIMIT_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [OP_W-1:0] OP_TEXT = 2'd0;
    localparam logic [OP_W-1:0] OP_MAP  = 2'd1;
    localparam logic [OP_W-1:0] OP_FILE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_LINES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEDS_IN_USE  = 1'd1;

    localparam logic [HDR_W-1:0]   HDR_RESET  = 4'd3;
    localparam logic [LIMIT_W-1:0] LEDS_RESET = 8'd128;

    localparam logic [CHAR_W-1:0] CHAR_NL   = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_SP   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_EOL   = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [LED_W-1:0]   led;
        logic [CH_W-1:0]    channel;
        logic [VAL_W-1:0]   value;
    } t_result;

    // acc*10 + (c - '0'), modulo 256
    function automatic logic [VAL_W-1:0] f_digit_step(input logic [VAL_W-1:0] acc,
                                                      input logic [CHAR_W-1:0] c);
        logic [VAL_W-1:0] x8;
        logic [VAL_W-1:0] x2;
        x8 = acc << 3;
        x2 = acc << 1;
        return x8 + x2 + c - CHAR_ZERO;
    endfunction

endpackage

`default_nettype wire

// ===== sv/appcp_in_if.sv =====
// ----------------------------------------------------------------------------
// appcp_in_if
// Input channel: text bytes, map entry writes and file starts.
// ----------------------------------------------------------------------------
`default_nettype none

interface appcp_in_if import appcp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [CHAR_W-1:0]   char_byte;
    logic [LED_W-1:0]    map_led;
    logic [CH_W-1:0]     map_channel;
    logic [MAPPOS_W-1:0] map_position;

    modport source (output valid, op, char_byte, map_led, map_channel, map_position,
                    input ready);
    modport sink   (input valid, op, char_byte, map_led, map_channel, map_position,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/appcp_out_if.sv =====
// ----------------------------------------------------------------------------
// appcp_out_if
// Output channel: pixel writes and end-of-line markers.
// ----------------------------------------------------------------------------
`default_nettype none

interface appcp_out_if import appcp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [LED_W-1:0]   led;
    logic [CH_W-1:0]    channel;
    logic [VAL_W-1:0]   value;

    modport source (output valid, kind, led, channel, value, input ready);
    modport sink   (input valid, kind, led, channel, value, output ready);
endinterface

`default_nettype wire

// ===== sv/ascii_pixel_row_column_picker.sv =====
// ----------------------------------------------------------------------------
// ascii_pixel_row_column_picker: one item per cycle if skid empty; registered out.
// Map lookups go through the map RAM read port, forwarded the cycle after a move.
// Sync reset clears pointer, token/digit counts, output valids; map RAM is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_pixel_row_column_picker import appcp_pkg::*; #(
    parameter int MAX_LEDS       = MAX_LEDS_DEF,
    parameter int CHANNELS       = CHANNELS_DEF,
    parameter int POSITION_WIDTH = POS_W_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    appcp_in_if.sink                   i_in,
    appcp_out_if.source                o_out
);

    `include "ascii_pixel_row_column_picker_assert.svh"

    logic    in_acc;
    logic    buf_room;
    logic    core_res_valid;
    t_result core_res;
    t_result out_item;

    assign i_in.ready = buf_room;
    assign in_acc     = i_in.valid && buf_room;

    appcp_core #(
        .MAX_LEDS       (MAX_LEDS),
        .CHANNELS       (CHANNELS),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_acc          (in_acc),
        .i_op           (i_in.op),
        .i_char_byte    (i_in.char_byte),
        .i_map_led      (i_in.map_led),
        .i_map_channel  (i_in.map_channel),
        .i_map_position (i_in.map_position),
        .o_res_valid    (core_res_valid),
        .o_res          (core_res)
    );

    appcp_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (core_res_valid),
        .i_item  (core_res),
        .o_room  (buf_room),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_item  (out_item)
    );

    assign o_out.kind    = out_item.kind;
    assign o_out.led     = out_item.led;
    assign o_out.channel = out_item.channel;
    assign o_out.value   = out_item.value;

    `APPCP_ASSERT_IMP(a_skid_implies_out, !i_in.ready, o_out.valid, "skid full, output empty")
    `APPCP_ASSERT_IMP(a_result_has_room, core_res_valid, i_in.ready, "result without room")
    `APPCP_ASSERT_NXT(a_stall_fills_skid, core_res_valid && o_out.valid && !o_out.ready, !i_in.ready, "stalled result not parked")
    `APPCP_ASSERT_IMP(a_eol_fields_zero, o_out.valid && o_out.kind == KIND_EOL, o_out.led == '0 && o_out.channel == '0 && o_out.value == '0, "line-done fields not zero")

endmodule

`default_nettype wire

// ===== sv/appcp_ram.sv =====
// ----------------------------------------------------------------------------
// appcp_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module appcp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 384,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/appcp_core.sv =====
// ----------------------------------------------------------------------------
// appcp_core
// Line parser: header skip, digit accumulate, space count, map pointer walk.
// The map lives in a RAM; a pointer move issues a read whose data is used
// directly in the next cycle (r_pend), then held in r_npos.
// ----------------------------------------------------------------------------
`default_nettype none

module appcp_core import appcp_pkg::*; #(
    parameter int MAX_LEDS       = MAX_LEDS_DEF,
    parameter int CHANNELS       = CHANNELS_DEF,
    parameter int POSITION_WIDTH = POS_W_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_acc,
    input  wire logic [OP_W-1:0]       i_op,
    input  wire logic [CHAR_W-1:0]     i_char_byte,
    input  wire logic [LED_W-1:0]      i_map_led,
    input  wire logic [CH_W-1:0]       i_map_channel,
    input  wire logic [MAPPOS_W-1:0]   i_map_position,
    output logic                       o_res_valid,
    output t_result                    o_res
);

    localparam int DEPTH = MAX_LEDS * CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LI_W  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CI_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW    = POSITION_WIDTH;

    logic [HDR_W-1:0]   r_hdr_lines, n_hdr_lines;
    logic [LIMIT_W-1:0] r_leds, n_leds;
    logic [HDR_W-1:0]   r_hdr_left, n_hdr_left;
    logic [PW-1:0]      r_tok, n_tok;
    logic [LI_W-1:0]    r_led, n_led;
    logic [CI_W-1:0]    r_ch, n_ch;
    logic [PW-1:0]      r_npos, n_npos;
    logic               r_pend, n_pend;
    logic [VAL_W-1:0]   r_digit, n_digit;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [PW-1:0]      ram_wdata, ram_rdata;

    logic [PW-1:0]      eff_pos, tok_inc;
    logic               map_ok, map_hit, pos_hit, led_wrap;
    logic [31:0]        led_lim;
    logic [LI_W-1:0]    adv_led;
    logic [CI_W-1:0]    adv_ch;

    appcp_ram #(
        .WIDTH (PW),
        .DEPTH (DEPTH)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // forward fresh read data in the cycle after a pointer move
    assign eff_pos = r_pend ? ram_rdata : r_npos;
    assign tok_inc = r_tok + 1'b1;
    assign pos_hit = (tok_inc == eff_pos);

    assign map_ok  = (32'(i_map_led) < MAX_LEDS) && (32'(i_map_channel) < CHANNELS);
    assign map_hit = map_ok && (32'(i_map_led) == 32'(r_led))
                            && (32'(i_map_channel) == 32'(r_ch));
    assign ram_waddr = AW'(32'(i_map_led) * CHANNELS + 32'(i_map_channel));
    assign ram_wdata = PW'(i_map_position);
    assign ram_raddr = AW'(32'(n_led) * CHANNELS + 32'(n_ch));

    // zero acts as one, above the table size acts as the table size
    assign led_lim  = (r_leds == '0) ? 32'd1 :
                      (32'(r_leds) > MAX_LEDS) ? 32'(MAX_LEDS) : 32'(r_leds);
    assign led_wrap = (32'(r_led) + 32'd1 >= led_lim);
    assign adv_led  = led_wrap ? '0 : r_led + 1'b1;
    assign adv_ch   = !led_wrap ? r_ch :
                      (32'(r_ch) + 32'd1 >= CHANNELS) ? '0 : r_ch + 1'b1;

    always_comb begin
        n_hdr_lines = r_hdr_lines;
        n_leds      = r_leds;
        n_hdr_left  = r_hdr_left;
        n_tok       = r_tok;
        n_led       = r_led;
        n_ch        = r_ch;
        n_npos      = eff_pos;
        n_pend      = 1'b0;
        n_digit     = r_digit;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HEADER_LINES: n_hdr_lines = i_cfg_wdata[HDR_W-1:0];
                CFG_LEDS_IN_USE:  n_leds      = i_cfg_wdata[LIMIT_W-1:0];
            endcase
        end

        if (i_acc) begin
            unique case (i_op)
                OP_MAP: begin
                    if (map_ok) begin
                        ram_we = 1'b1;
                        if (map_hit) begin
                            n_npos = ram_wdata;
                        end
                    end
                end
                OP_FILE: begin
                    n_hdr_left = r_hdr_lines;
                    n_tok      = '0;
                    n_led      = '0;
                    n_ch       = '0;
                    n_digit    = '0;
                    ram_re     = 1'b1;
                    n_pend     = 1'b1;
                end
                OP_TEXT: begin
                    if (r_hdr_left != '0) begin
                        if (i_char_byte == CHAR_NL) begin
                            n_hdr_left = r_hdr_left - 1'b1;
                        end
                    end else if (i_char_byte == CHAR_NL) begin
                        n_tok       = '0;
                        n_led       = '0;
                        n_ch        = '0;
                        n_digit     = '0;
                        ram_re      = 1'b1;
                        n_pend      = 1'b1;
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_EOL;
                    end else if (i_char_byte == CHAR_SP) begin
                        n_tok   = tok_inc;
                        n_digit = '0;
                        if (pos_hit) begin
                            o_res_valid   = 1'b1;
                            o_res.kind    = KIND_PIXEL;
                            o_res.led     = LED_W'(r_led);
                            o_res.channel = CH_W'(r_ch);
                            o_res.value   = r_digit;
                            n_led         = adv_led;
                            n_ch          = adv_ch;
                            ram_re        = 1'b1;
                            n_pend        = 1'b1;
                        end
                    end else begin
                        n_digit = f_digit_step(r_digit, i_char_byte);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_lines <= HDR_RESET;
            r_leds      <= LEDS_RESET;
            r_hdr_left  <= HDR_RESET;
            r_tok       <= '0;
            r_led       <= '0;
            r_ch        <= '0;
            r_npos      <= '0;
            r_pend      <= 1'b0;
            r_digit     <= '0;
        end else begin
            r_hdr_lines <= n_hdr_lines;
            r_leds      <= n_leds;
            r_hdr_left  <= n_hdr_left;
            r_tok       <= n_tok;
            r_led       <= n_led;
            r_ch        <= n_ch;
            r_npos      <= n_npos;
            r_pend      <= n_pend;
            r_digit     <= n_digit;
        end
    end

endmodule

`default_nettype wire

// ===== sv/appcp_outbuf.sv =====
// ----------------------------------------------------------------------------
// appcp_outbuf
// Output register with a one-entry skid stage.
// ----------------------------------------------------------------------------
`default_nettype none

module appcp_outbuf import appcp_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_item,
    output logic         o_room,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_item
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    assign o_room  = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = i_item;
                n_out_valid = i_push;
            end
        end else if (i_push) begin
            // output stalled: park the new result
            n_skid       = i_item;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

`default_nettype wire

// ===== dv/appcp_pixel_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// appcp_pixel_checker
// Watches both channels and the register port of the row/column picker,
// predicts each pixel write and end-of-line marker, and compares them in order.
// ----------------------------------------------------------------------------
module appcp_pixel_checker import appcp_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    appcp_in_if                        i_in_mon,
    appcp_out_if                       i_out_mon,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam int MAP_DEPTH = MAX_LEDS_DEF * CHANNELS_DEF;

    logic [POS_W_DEF-1:0]  pos_map [MAP_DEPTH];
    logic [POS_W_DEF-1:0]  space_cnt;
    logic [POS_W_DEF-1:0]  target_pos;
    logic [LED_W-1:0]      led_ptr;
    logic [CH_W-1:0]       ch_ptr;
    logic [VAL_W-1:0]      acc;
    logic [HDR_W-1:0]      hdr_lines;
    logic [HDR_W-1:0]      hdr_left;
    logic [LIMIT_W-1:0]    leds_reg;
    t_result               due_writes [$];
    int                    mismatches = 0;

    initial begin
        foreach (pos_map[k]) pos_map[k] = '0;
    end

    task automatic restart_line();
        space_cnt  = '0;
        led_ptr    = '0;
        ch_ptr     = '0;
        acc        = '0;
        target_pos = pos_map[0];
    endtask

    // one accepted transaction on the input channel
    task automatic advance_picker(input logic [OP_W-1:0]     op,
                                  input logic [CHAR_W-1:0]   c,
                                  input logic [LED_W-1:0]    mled,
                                  input logic [CH_W-1:0]     mch,
                                  input logic [MAPPOS_W-1:0] mpos);
        t_result r;
        int      lim;
        case (op)
            OP_MAP: begin
                if (int'(mch) < CHANNELS_DEF && int'(mled) < MAX_LEDS_DEF) begin
                    pos_map[int'(mled) * CHANNELS_DEF + int'(mch)] = POS_W_DEF'(mpos);
                    if (mled == led_ptr && mch == ch_ptr) target_pos = POS_W_DEF'(mpos);
                end
            end
            OP_FILE: begin
                hdr_left = hdr_lines;
                restart_line();
            end
            OP_TEXT: begin
                if (hdr_left != 0) begin
                    if (c == CHAR_NL) hdr_left = hdr_left - 1'b1;
                end else if (c == CHAR_NL) begin
                    restart_line();
                    r         = '0;
                    r.kind    = KIND_EOL;
                    due_writes.push_back(r);
                end else if (c == CHAR_SP) begin
                    space_cnt = space_cnt + 1'b1;
                    if (space_cnt == target_pos) begin
                        r.kind    = KIND_PIXEL;
                        r.led     = led_ptr;
                        r.channel = ch_ptr;
                        r.value   = acc;
                        due_writes.push_back(r);
                        lim = (leds_reg == 0) ? 1 :
                              (int'(leds_reg) > MAX_LEDS_DEF) ? MAX_LEDS_DEF : int'(leds_reg);
                        if (int'(led_ptr) + 1 < lim) begin
                            led_ptr = led_ptr + 1'b1;
                        end else begin
                            led_ptr = '0;
                            ch_ptr  = (int'(ch_ptr) + 1 >= CHANNELS_DEF) ? '0 : ch_ptr + 1'b1;
                        end
                        target_pos = pos_map[int'(led_ptr) * CHANNELS_DEF + int'(ch_ptr)];
                    end
                    acc = '0;
                end else begin
                    // anything else is taken as a digit, wrapping at 8 bits
                    acc = VAL_W'(int'(acc) * 10 + int'(c) - int'(CHAR_ZERO));
                end
            end
            default: ;  // unused opcode, dropped
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            hdr_lines = HDR_RESET;
            leds_reg  = LEDS_RESET;
            hdr_left  = HDR_RESET;
            restart_line();
            due_writes.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HEADER_LINES: hdr_lines = i_cfg_wdata[HDR_W-1:0];
                    CFG_LEDS_IN_USE:  leds_reg  = i_cfg_wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready)
                advance_picker(i_in_mon.op, i_in_mon.char_byte, i_in_mon.map_led,
                               i_in_mon.map_channel, i_in_mon.map_position);
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.kind    = i_out_mon.kind;
                got.led     = i_out_mon.led;
                got.channel = i_out_mon.channel;
                got.value   = i_out_mon.value;
                if (due_writes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t appcp_pixel_checker: unexpected result kind %0d led %0d ch %0d value %0d",
                                 $realtime, got.kind, got.led, got.channel, got.value);
                end else begin
                    want = due_writes.pop_front();
                    if (got.kind !== want.kind || got.led !== want.led ||
                        got.channel !== want.channel || got.value !== want.value) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t appcp_pixel_checker: mismatch, expected kind %0d led %0d ch %0d value %0d, got kind %0d led %0d ch %0d value %0d",
                                     $realtime, want.kind, want.led, want.channel, want.value,
                                     got.kind, got.led, got.channel, got.value);
                    end
                end
            end
        end
        o_fail_count = mismatches;
        o_pending    = due_writes.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives text bytes, map writes and file starts into the row/column picker
// under random idling and long output stalls; the checker judges the results.
// ----------------------------------------------------------------------------
module tb_top import appcp_pkg::*; ();

    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int tx_gap_pct = 35;
    int rx_gap_pct = 83;
    int hold_left  = 0;
    int data_items = 0;
    int hdr_now    = 3;
    int eff_now    = MAX_LEDS_DEF;
    int fails;
    int pending;

    appcp_in_if  in_ch ();
    appcp_out_if out_ch ();

    ascii_pixel_row_column_picker i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    appcp_pixel_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fails),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random back-pressure, or a long counted hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_gap_pct);
            end
        end
    end

    initial begin
        #500_000;
        $display("tb_top: done, errors");
        $finish;
    end

    task automatic offer(input logic [OP_W-1:0]     op,
                         input logic [CHAR_W-1:0]   c,
                         input logic [LED_W-1:0]    led,
                         input logic [CH_W-1:0]     ch,
                         input logic [MAPPOS_W-1:0] pos);
        while (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.op           <= op;
        in_ch.char_byte    <= c;
        in_ch.map_led      <= led;
        in_ch.map_channel  <= ch;
        in_ch.map_position <= pos;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] c);
        offer(OP_TEXT, c, LED_W'($urandom), CH_W'($urandom), MAPPOS_W'($urandom));
    endtask

    task automatic put_map(input logic [LED_W-1:0] led, input logic [CH_W-1:0] ch,
                           input logic [MAPPOS_W-1:0] pos);
        offer(OP_MAP, CHAR_W'($urandom), led, ch, pos);
    endtask

    task automatic put_file();
        offer(OP_FILE, CHAR_W'($urandom), LED_W'($urandom), CH_W'($urandom),
              MAPPOS_W'($urandom));
    endtask

    task automatic put_text(input string s);
        for (int k = 0; k < s.len(); k++) put_char(s[k]);
    endtask

    function automatic logic [CHAR_W-1:0] pick_digit();
        logic [CHAR_W-1:0] c;
        if ($urandom_range(9) != 0) return CHAR_ZERO + CHAR_W'($urandom_range(9));
        do c = CHAR_W'($urandom); while (c == CHAR_NL || c == CHAR_SP);
        return c;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // stop offering until every expected transaction is out, plus pipeline slack
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // positions rise along the walk order: led first, then channel
    task automatic load_map(input int eff);
        int pos;
        pos = 0;
        for (int ch = 0; ch < CHANNELS_DEF; ch++) begin
            for (int led = 0; led < eff; led++) begin
                pos += (eff > 16) ? 1 : $urandom_range(1, 2);
                put_map(LED_W'(led), CH_W'(ch), MAPPOS_W'(pos));
            end
        end
    endtask

    task automatic send_header(input int n);
        repeat (n) begin
            repeat ($urandom_range(4)) begin
                if ($urandom_range(1)) put_char(CHAR_SP);
                else put_char(pick_digit());
            end
            put_char(CHAR_NL);
        end
    endtask

    task automatic send_line();
        int ntok;
        int ndig;
        int hi;
        logic [LED_W-1:0] led;
        if ($urandom_range(14) == 0) begin
            put_file();
            send_header(hdr_now);
        end
        hi   = (3 * eff_now + 2 < 16) ? 3 * eff_now + 2 : 16;
        ntok = $urandom_range(1, hi);
        repeat (ntok) begin
            ndig = $urandom_range(3);
            repeat (ndig) put_char(pick_digit());
            if ($urandom_range(19) == 0) begin
                led = ($urandom_range(3) == 0) ? LED_W'($urandom_range(127))
                                                : LED_W'($urandom_range(eff_now - 1));
                put_map(led, CH_W'($urandom_range(3)),
                        ($urandom_range(9) == 0) ? MAPPOS_W'($urandom)
                                                 : MAPPOS_W'($urandom_range(1, 16)));
                data_items++;
            end
            if ($urandom_range(29) == 0)
                offer(OP_NONE, CHAR_W'($urandom), LED_W'($urandom), CH_W'($urandom),
                      MAPPOS_W'($urandom));
            put_char(CHAR_SP);
            data_items += ndig + 1;
        end
        // now and then the newline is left off and lines run together
        if ($urandom_range(9) != 0) begin
            put_char(CHAR_NL);
            data_items++;
        end
    endtask

    task automatic setup_phase(input logic [CFG_DATA_W-1:0] hdr,
                               input logic [CFG_DATA_W-1:0] leds,
                               input int tx, input int rx);
        settle();
        cfg_write(CFG_HEADER_LINES, hdr);
        cfg_write(CFG_LEDS_IN_USE, leds);
        tx_gap_pct = tx;
        rx_gap_pct = rx;
        hdr_now    = int'(hdr[HDR_W-1:0]);
        eff_now    = (leds == 0) ? 1 :
                     (int'(leds) > MAX_LEDS_DEF) ? MAX_LEDS_DEF : int'(leds);
        load_map(eff_now);
        put_file();
        send_header(hdr_now);
        data_items = 0;
    endtask

    task automatic random_lines(input int budget);
        while (data_items < budget) send_line();
    endtask

    initial begin
        in_ch.valid        <= 1'b0;
        in_ch.op           <= OP_TEXT;
        in_ch.char_byte    <= '0;
        in_ch.map_led      <= '0;
        in_ch.map_channel  <= '0;
        in_ch.map_position <= '0;
        cfg_we             <= 1'b0;
        cfg_idx            <= CFG_HEADER_LINES;
        cfg_wdata          <= '0;
        rst_n              <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // channel 0 in full and the start of channel 1, positions counting up
        // along the walk; the pointer never gets past these before a phase reload
        for (int k = 0; k < MAX_LEDS_DEF + 16; k++) begin
            put_map(LED_W'(k % MAX_LEDS_DEF), CH_W'(k / MAX_LEDS_DEF), MAPPOS_W'(k + 1));
        end
        put_map(LED_W'(127), CH_W'(3), 16'hFFFF);  // no such channel: dropped
        // three header lines after reset, content ignored
        put_text("1 2\n\n");
        put_char(8'hFF);
        put_char(CHAR_NL);
        // 255, wrap to 0, 999 -> 231, empty token
        put_text("255 256 999  ");
        put_char(8'h41);
        put_char(CHAR_SP);
        put_char(8'hFF);
        put_char(8'h00);
        put_char(CHAR_SP);
        // retarget the entry the pointer rests on
        put_map(LED_W'(6), CH_W'(0), 16'd9);
        put_text("1 2 3 ");
        offer(OP_NONE, 8'hA5, LED_W'(85), CH_W'(1), 16'h5A5A);
        put_map(LED_W'(7), CH_W'(0), 16'd10);
        put_text("7 \n");
        put_file();
        put_text("\n\n\n");

        // 255 acts as 128: the walk runs through channel 0 into channel 1,
        // with a long output stall while the sender keeps pushing
        settle();
        cfg_write(CFG_HEADER_LINES, 8'd1);
        cfg_write(CFG_LEDS_IN_USE, 8'd255);
        put_map(LED_W'(6), CH_W'(0), 16'd7);
        put_map(LED_W'(7), CH_W'(0), 16'd8);
        put_file();
        send_header(1);
        hold_left = 300;
        repeat (136) begin
            if ($urandom_range(7) == 0) put_char(pick_digit());
            put_char(CHAR_SP);
        end
        put_char(CHAR_NL);

        setup_phase(8'd0, 8'd3, 35, 83);
        random_lines(25);
        setup_phase(8'd15, 8'd1, 35, 83);
        random_lines(25);
        setup_phase(8'hF0, 8'd0, 83, 35);
        random_lines(25);
        setup_phase(8'd7, 8'd2, 83, 35);
        random_lines(25);
        setup_phase(CFG_DATA_W'($urandom_range(15)), CFG_DATA_W'($urandom_range(4, 16)), 0, 0);
        random_lines(25);

        settle();
        repeat (10) @(posedge clk);
        if (fails == 0 && pending == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/appcp_pkg.sv
sv/appcp_in_if.sv
sv/appcp_out_if.sv
sv/appcp_ram.sv
sv/appcp_core.sv
sv/appcp_outbuf.sv
sv/ascii_pixel_row_column_picker.sv
dv/appcp_pixel_checker.sv
dv/tb_top.sv
